// File: src/adc_alternating_channel_poller_macros.svh
// Assertion macros shared by the poller RTL files.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ADC_ALTERNATING_CHANNEL_POLLER_MACROS_SVH
`define ADC_ALTERNATING_CHANNEL_POLLER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ACP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ACP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/acp_pkg.sv
// Shared types and constants for the alternating channel ADC poller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package acp_pkg;

    // Configuration defaults and register indexes
    localparam logic [6:0]  ACP_BUS_ADDRESS_RST   = 7'd72;
    localparam logic [15:0] ACP_BASE_SETTING_RST  = 16'd1920;
    localparam logic [15:0] ACP_PROBE_SETTING_RST = 16'd1408;

    localparam logic [1:0] CFG_BUS_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_BASE_SETTING  = 2'd1;
    localparam logic [1:0] CFG_PROBE_SETTING = 2'd2;

    // Converter command constants
    localparam logic [7:0]  ACP_CONFIG_REG = 8'h01;
    localparam logic [15:0] ACP_START_BIT  = 16'h8000;
    localparam logic [15:0] ACP_MUX_CH0    = 16'h1000;
    localparam logic [15:0] ACP_MUX_CH1    = 16'h2000;
    localparam logic [15:0] ACP_MIN_SLOT_MS  = 16'd2;
    localparam logic [16:0] ACP_MAX_POINT_MS = 17'd100;

    localparam int ACP_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        FN_INIT  = 2'd0,
        FN_SLOT  = 2'd1,
        FN_DONE  = 2'd2,
        FN_ERROR = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        PH_UNINIT  = 4'd0,
        PH_STARTED = 4'd1,
        PH_PROBING = 4'd2,
        PH_ABSENT  = 4'd3,
        PH_READY   = 4'd4,
        PH_STEP1   = 4'd5,
        PH_STEP2   = 4'd6,
        PH_STEP3   = 4'd7,
        PH_HALTED  = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_REINIT  = 3'd1,
        FLT_TIMING  = 3'd2,
        FLT_OVERRUN = 3'd3,
        FLT_STRAY   = 3'd4,
        FLT_BUSERR  = 3'd5
    } t_fault;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_READ     = 3'd2,
        KIND_PRESENCE = 3'd3,
        KIND_SAMPLE   = 3'd4,
        KIND_FAULT    = 3'd5
    } t_kind;

    // Work handed from the front to the back
    typedef enum logic [2:0] {
        JOB_FAULT    = 3'd0,
        JOB_PROBE    = 3'd1,
        JOB_POINTER  = 3'd2,
        JOB_READ     = 3'd3,
        JOB_PRESENCE = 3'd4,
        JOB_SAMPLE   = 3'd5
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] value;
        logic        chan;
        logic [31:0] stamp;
        logic        present;
        t_fault      fault;
    } t_job;

    typedef struct packed {
        logic [6:0]  bus_address;
        logic [15:0] base_setting;
        logic [15:0] probe_setting;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic [6:0]         target;
        logic [1:0]         byte_count;
        logic [7:0]         tx_first;
        logic [7:0]         tx_second;
        logic [7:0]         tx_third;
        logic signed [15:0] sample_value;
        logic               sample_channel;
        logic [31:0]        sample_time;
        logic               present;
        t_fault             fault_code;
    } t_result;

endpackage

`default_nettype wire

// File: src/acp_queue.sv
// Short job queue between the event front end and the result back end.
// Depends on acp_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module acp_queue
    import acp_pkg::*;
#(
    parameter int DEPTH = ACP_QUEUE_DEPTH
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_push_job,
    output logic  o_full,
    input  wire   i_pop,
    output t_job  o_head,
    output logic  o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push, do_pop;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop  ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// File: src/acp_front.sv
// Event front end: accepts transactions, runs the sequencing state machine
// and queues one job per event that yields results. Depends on acp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "adc_alternating_channel_poller_macros.svh"

module acp_front
    import acp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_func,
    input  wire  [31:0] i_slot_time,
    input  wire  [15:0] i_rx_word,
    input  wire  [15:0] i_slot_length,
    input  wire  [15:0] i_slot_spacing,
    input  wire         i_full,
    output logic        o_push,
    output t_job        o_job
);

    t_phase      r_phase,  n_phase;
    logic        r_chan,   n_chan;
    logic [31:0] r_prev,   n_prev;
    logic [31:0] r_cur,    n_cur;
    t_fault      r_sticky, n_sticky;
    logic        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_UNINIT;
            r_chan   <= 1'b0;
            r_prev   <= '0;
            r_cur    <= '0;
            r_sticky <= FLT_NONE;
        end else begin
            r_phase  <= n_phase;
            r_chan   <= n_chan;
            r_prev   <= n_prev;
            r_cur    <= n_cur;
            r_sticky <= n_sticky;
        end
    end

    always_comb begin
        logic   raise;
        t_fault code;
        logic   bad_timing;

        raise      = 1'b0;
        code       = FLT_NONE;
        bad_timing = (i_slot_length < ACP_MIN_SLOT_MS)
                  || ({i_slot_spacing, 1'b0} > ACP_MAX_POINT_MS);
        n_phase  = r_phase;
        n_chan   = r_chan;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_sticky = r_sticky;
        o_push   = 1'b0;
        o_job    = '0;

        if (accept) begin
            if (r_phase == PH_HALTED) begin
                // repeat the latched code, change nothing
                o_push      = 1'b1;
                o_job.kind  = JOB_FAULT;
                o_job.fault = r_sticky;
            end else begin
                unique case (t_func'(i_func))
                    FN_INIT: begin
                        if (r_phase != PH_UNINIT) begin
                            raise = 1'b1;
                            code  = FLT_REINIT;
                        end else if (bad_timing) begin
                            raise = 1'b1;
                            code  = FLT_TIMING;
                        end else begin
                            n_phase = PH_STARTED;
                        end
                    end
                    FN_SLOT: begin
                        if (r_phase == PH_STARTED || r_phase == PH_ABSENT
                                || r_phase == PH_READY) begin
                            n_prev = r_cur;
                            n_cur  = i_slot_time;
                            if (r_phase == PH_STARTED) begin
                                n_phase    = PH_PROBING;
                                o_push     = 1'b1;
                                o_job.kind = JOB_PROBE;
                            end else if (r_phase == PH_READY) begin
                                n_phase    = PH_STEP1;
                                o_push     = 1'b1;
                                o_job.kind = JOB_POINTER;
                            end
                        end else begin
                            raise = 1'b1;
                            code  = FLT_OVERRUN;
                        end
                    end
                    FN_DONE: begin
                        priority case (r_phase)
                            PH_PROBING: begin
                                n_phase       = PH_READY;
                                o_push        = 1'b1;
                                o_job.kind    = JOB_PRESENCE;
                                o_job.present = 1'b1;
                            end
                            PH_STEP1: begin
                                n_phase    = PH_STEP2;
                                o_push     = 1'b1;
                                o_job.kind = JOB_READ;
                            end
                            PH_STEP2: begin
                                n_phase     = PH_STEP3;
                                n_chan      = ~r_chan;
                                o_push      = 1'b1;
                                o_job.kind  = JOB_SAMPLE;
                                o_job.value = i_rx_word;
                                o_job.chan  = r_chan;
                                o_job.stamp = r_prev;
                            end
                            PH_STEP3: begin
                                n_phase = PH_READY;
                            end
                            default: begin
                                raise = 1'b1;
                                code  = FLT_STRAY;
                            end
                        endcase
                    end
                    FN_ERROR: begin
                        if (r_phase == PH_PROBING) begin
                            n_phase       = PH_ABSENT;
                            o_push        = 1'b1;
                            o_job.kind    = JOB_PRESENCE;
                            o_job.present = 1'b0;
                        end else begin
                            raise = 1'b1;
                            code  = FLT_BUSERR;
                        end
                    end
                    default: ;
                endcase

                if (raise) begin
                    // latch the code and halt until reset
                    n_phase     = PH_HALTED;
                    n_sticky    = code;
                    o_push      = 1'b1;
                    o_job       = '0;
                    o_job.kind  = JOB_FAULT;
                    o_job.fault = code;
                end
            end
        end
    end

    `ACP_ASSERT_IMPLY(a_halt_has_code, r_phase == PH_HALTED, r_sticky != FLT_NONE,
        "halted without a fault code")
    `ACP_ASSERT_NEXT(a_halt_is_final, r_phase == PH_HALTED, r_phase == PH_HALTED,
        "left the halt without reset")
    `ACP_ASSERT_NEXT(a_sticky_holds, r_phase == PH_HALTED, $stable(r_sticky),
        "fault code changed while halted")

endmodule

`default_nettype wire

// File: src/acp_back.sv
// Result back end: expands queued jobs into result transactions and holds
// them in the output register. Depends on acp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "adc_alternating_channel_poller_macros.svh"

module acp_back
    import acp_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_cfg     i_cfg,
    input  t_job     i_head,
    input  wire      i_empty,
    output logic     o_pop,
    output logic     o_valid,
    input  wire      i_ready,
    output t_result  o_res
);

    logic    r_valid, n_valid;
    logic    r_sub,   n_sub;
    t_result r_res,   n_res;
    logic    can_load, load, two_part;
    logic [15:0] cfg_word;

    assign can_load = !r_valid || i_ready;
    assign load     = can_load && !i_empty;
    assign two_part = (i_head.kind == JOB_SAMPLE) && !r_sub;
    assign o_pop    = load && !two_part;
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    // the conversion that starts next runs on the other channel
    assign cfg_word = i_cfg.base_setting | ACP_START_BIT
                    | (i_head.chan ? ACP_MUX_CH0 : ACP_MUX_CH1);

    always_comb begin
        n_res      = '0;
        n_res.last = 1'b1;
        unique case (i_head.kind)
            JOB_FAULT: begin
                n_res.kind       = KIND_FAULT;
                n_res.fault_code = i_head.fault;
            end
            JOB_PROBE: begin
                n_res.kind       = KIND_WRITE;
                n_res.target     = i_cfg.bus_address;
                n_res.byte_count = 2'd3;
                n_res.tx_first   = ACP_CONFIG_REG;
                n_res.tx_second  = i_cfg.probe_setting[15:8];
                n_res.tx_third   = i_cfg.probe_setting[7:0];
            end
            JOB_POINTER: begin
                n_res.kind       = KIND_WRITE;
                n_res.target     = i_cfg.bus_address;
                n_res.byte_count = 2'd1;
            end
            JOB_READ: begin
                n_res.kind       = KIND_READ;
                n_res.target     = i_cfg.bus_address;
                n_res.byte_count = 2'd2;
            end
            JOB_PRESENCE: begin
                n_res.kind    = KIND_PRESENCE;
                n_res.present = i_head.present;
            end
            JOB_SAMPLE: begin
                if (!r_sub) begin
                    n_res.kind           = KIND_SAMPLE;
                    n_res.last           = 1'b0;
                    n_res.sample_value   = i_head.value;
                    n_res.sample_channel = i_head.chan;
                    n_res.sample_time    = i_head.stamp;
                end else begin
                    n_res.kind       = KIND_WRITE;
                    n_res.target     = i_cfg.bus_address;
                    n_res.byte_count = 2'd3;
                    n_res.tx_first   = ACP_CONFIG_REG;
                    n_res.tx_second  = cfg_word[15:8];
                    n_res.tx_third   = cfg_word[7:0];
                end
            end
            default: begin
                n_res.kind = KIND_NONE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = two_part;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    `ACP_ASSERT_IMPLY(a_sub_on_sample, r_sub,
        !i_empty && i_head.kind == JOB_SAMPLE, "second half without a sample job")
    `ACP_ASSERT_IMPLY(a_not_last_is_sample, r_valid && !r_res.last,
        r_res.kind == KIND_SAMPLE, "only a sample may be followed by a result")
    `ACP_ASSERT_NEXT(a_sample_then_write, load && two_part,
        r_sub && r_valid && r_res.kind == KIND_SAMPLE, "sample not staged before write")

endmodule

`default_nettype wire

// File: src/adc_alternating_channel_poller.sv
// Top level of the two-channel ADC poller: configuration registers, front
// end, job queue and back end. Depends on acp_pkg, acp_front, acp_queue, acp_back.
//
//  channel   direction  handshake             payload
//  events    in         i_s_tvalid/o_s_tready tuser func, tdata timing and rx word
//  results   out        o_m_tvalid/i_m_tready tuser kind, tlast, tdata result fields
//  config    in         i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// An event is taken whenever the job queue has room.
// Results leave one per cycle while the output is not stalled; a read completion
// yields the sample and then the next config write from one queued job.
// While the output is stalled the queue fills; once it is full o_s_tready drops.
// Reset is synchronous and clears the sequencer and the queue at once.
`timescale 1ns / 1ps
`default_nettype none

module adc_alternating_channel_poller
    import acp_pkg::*;
#(
    parameter int QUEUE_DEPTH = ACP_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [79:0] i_s_tdata,   // slot_time, rx_word, slot_length, slot_spacing
    input  wire  [1:0]  i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [87:0] o_m_tdata,   // target, byte_count, tx_first, tx_second,
                                     // tx_third, sample_value, sample_channel,
                                     // sample_time, present, fault_code, zero pad
    output logic [2:0]  o_m_tuser,   // kind
    output logic        o_m_tlast,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    push, full, pop, empty;
    t_job    push_job, head;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_address   <= ACP_BUS_ADDRESS_RST;
            r_cfg.base_setting  <= ACP_BASE_SETTING_RST;
            r_cfg.probe_setting <= ACP_PROBE_SETTING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BUS_ADDRESS:   r_cfg.bus_address   <= i_cfg_wdata[6:0];
                CFG_BASE_SETTING:  r_cfg.base_setting  <= i_cfg_wdata;
                CFG_PROBE_SETTING: r_cfg.probe_setting <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    acp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_func         (i_s_tuser),
        .i_slot_time    (i_s_tdata[31:0]),
        .i_rx_word      (i_s_tdata[47:32]),
        .i_slot_length  (i_s_tdata[63:48]),
        .i_slot_spacing (i_s_tdata[79:64]),
        .i_full         (full),
        .o_push         (push),
        .o_job          (push_job)
    );

    acp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (empty)
    );

    acp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;
    assign o_m_tdata = {2'b00, res.fault_code, res.present, res.sample_time,
                        res.sample_channel, res.sample_value, res.tx_third,
                        res.tx_second, res.tx_first, res.byte_count, res.target};

endmodule

`default_nettype wire
